FILE: rtl/adaptive_irrigation_timer_top_assert.svh
// Assertion macros for the irrigation timer checker.
// Depends on nothing; included by the checker file.
`ifndef ADAPTIVE_IRRIGATION_TIMER_TOP_ASSERT_SVH
`define ADAPTIVE_IRRIGATION_TIMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define AIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define AIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ait_pkg.sv
// Shared types, reset values, opcodes and the watering interval ROM.
// Used by every module of the irrigation timer; depends on nothing.
package ait_pkg;

    localparam int ADC_BITS_DEF        = 12;
    localparam int ADC_SCALE_SHIFT_DEF = 11;

    localparam int TEMP_W     = 8;
    localparam int FILT_W     = 16;
    localparam int IVAL_W     = 20;
    localparam int OPEN_W     = 16;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int M_DATA_W   = 64;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_DAILY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_SECS  = 2'd2;

    localparam logic [TEMP_W-1:0] LOW_LIMIT_RST  = 8'd4;
    localparam logic [TEMP_W-1:0] HIGH_LIMIT_RST = 8'd60;
    localparam logic [OPEN_W-1:0] OPEN_SECS_RST  = 16'd30;
    localparam logic [FILT_W-1:0] FILT_RST       = 16'd2560;
    localparam logic [TEMP_W-1:0] PEAK_RST       = 8'd4;
    localparam logic [IVAL_W-1:0] IVAL_RST       = 20'd84600;
    localparam logic [IVAL_W-1:0] COUNTDOWN_RST  = 20'd50400;

    // floor(x / 10) = (x * 52429) >> 19 for every x below 2**18
    localparam logic [16:0] DIV10_RECIP = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam int ROM_DEPTH = 256;
    localparam int IVAL_MAX  = 1048575;

    typedef logic [IVAL_W-1:0] t_interval_rom [ROM_DEPTH];

    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] op;
        logic [TEMP_W-1:0] target;
    } t_item;

    typedef struct packed {
        logic              valve_open;
        logic [TEMP_W-1:0] max_temperature;
        logic [IVAL_W-1:0] watering_interval;
        logic [IVAL_W-1:0] seconds_to_next;
    } t_valve_status;

    // Interval per daily maximum: floor(3203616.1 * m ** -1.3724), m at least 4.
    function automatic t_interval_rom build_interval_rom();
        t_interval_rom rom;
        real           v;
        int            m;
        int            iv;
        for (int idx = 0; idx < ROM_DEPTH; idx++) begin
            m  = (idx < 4) ? 4 : idx;
            v  = 3203616.1 * ($itor(m) ** (-1.3724));
            iv = $rtoi(v);
            if (iv > IVAL_MAX) begin
                iv = IVAL_MAX;
            end
            rom[idx] = IVAL_W'(iv);
        end
        return rom;
    endfunction

    localparam t_interval_rom INTERVAL_ROM = build_interval_rom();

endpackage

FILE: rtl/ait_input_stage.sv
// Input register of the irrigation timer: takes a request, scales the sample.
// Depends on ait_pkg.
module ait_input_stage #(
    parameter int ADC_BITS        = ait_pkg::ADC_BITS_DEF,
    parameter int ADC_SCALE_SHIFT = ait_pkg::ADC_SCALE_SHIFT_DEF,
    parameter int S_DATA_W        = ((ADC_BITS + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_tvalid,
    output logic                      o_tready,
    input  logic [S_DATA_W-1:0]       i_tdata,
    input  logic [ait_pkg::OP_W-1:0]  i_tuser,
    input  logic                      i_advance,
    output ait_pkg::t_item            o_item
);

    localparam int PROD_W = ADC_BITS + 7;

    logic                           r_valid;
    logic [ait_pkg::OP_W-1:0]       r_op;
    logic [ait_pkg::TEMP_W-1:0]     r_target;
    logic [ADC_BITS-1:0]            adc;
    logic [PROD_W-1:0]              scaled;
    logic [PROD_W-1:0]              shifted;
    logic [ait_pkg::TEMP_W-1:0]     target;
    logic                           accept;

    assign adc     = i_tdata[ADC_BITS-1:0];
    assign scaled  = PROD_W'(adc) * PROD_W'(7'd100);
    assign shifted = scaled >> ADC_SCALE_SHIFT;
    assign target  = (shifted > PROD_W'(255)) ? 8'hFF : shifted[ait_pkg::TEMP_W-1:0];

    assign o_tready = !r_valid || i_advance;
    assign accept   = i_tvalid && o_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_tuser;
            r_target <= target;
        end
    end

    assign o_item.valid  = r_valid;
    assign o_item.op     = r_op;
    assign o_item.target = r_target;

endmodule

FILE: rtl/ait_temp_filter.sv
// Q8.8 filtered temperature: moves one tenth of the way toward each sample.
// Depends on ait_pkg.
module ait_temp_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_update,
    input  logic [ait_pkg::TEMP_W-1:0]  i_target,
    output logic [ait_pkg::TEMP_W-1:0]  o_whole,
    output logic [ait_pkg::TEMP_W-1:0]  o_whole_next
);

    logic [ait_pkg::FILT_W-1:0] r_filt;
    logic [ait_pkg::FILT_W-1:0] n_filt;
    logic signed [17:0]         diff;
    logic [16:0]                diff_abs;
    logic [34:0]                prod;
    logic [ait_pkg::FILT_W-1:0] quot;

    assign diff     = $signed({2'b00, i_target, 8'h00}) - $signed({2'b00, r_filt});
    assign diff_abs = diff[17] ? 17'(-diff) : 17'(diff);
    assign prod     = 35'(diff_abs) * 35'(ait_pkg::DIV10_RECIP);
    assign quot     = prod[ait_pkg::DIV10_SHIFT +: ait_pkg::FILT_W];

    // Quotient truncates toward zero, so apply it to the magnitude.
    always_comb begin
        n_filt = r_filt;
        if (i_update) begin
            n_filt = diff[17] ? (r_filt - quot) : (r_filt + quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= ait_pkg::FILT_RST;
        end else begin
            r_filt <= n_filt;
        end
    end

    assign o_whole      = r_filt[ait_pkg::FILT_W-1 -: ait_pkg::TEMP_W];
    assign o_whole_next = n_filt[ait_pkg::FILT_W-1 -: ait_pkg::TEMP_W];

endmodule

FILE: rtl/ait_valve_ctrl.sv
// Valve timing: limits, daily peak, countdowns and interval lookup.
// Depends on ait_pkg.
module ait_valve_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ait_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ait_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_advance,
    input  logic [ait_pkg::OP_W-1:0]        i_op,
    input  logic [ait_pkg::TEMP_W-1:0]      i_temp_whole,
    output ait_pkg::t_valve_status          o_next
);

    logic [ait_pkg::TEMP_W-1:0] r_low;
    logic [ait_pkg::TEMP_W-1:0] r_high;
    logic [ait_pkg::OPEN_W-1:0] r_open_secs;
    logic [ait_pkg::TEMP_W-1:0] r_peak;
    logic [ait_pkg::TEMP_W-1:0] n_peak;
    logic [ait_pkg::IVAL_W-1:0] r_ival;
    logic [ait_pkg::IVAL_W-1:0] n_ival;
    logic [ait_pkg::IVAL_W-1:0] r_open_cnt;
    logic [ait_pkg::IVAL_W-1:0] n_open_cnt;
    logic [ait_pkg::OPEN_W-1:0] r_close_cnt;
    logic [ait_pkg::OPEN_W-1:0] n_close_cnt;
    logic                       r_valve;
    logic                       n_valve;
    logic [ait_pkg::IVAL_W-1:0] open_dec;
    logic [ait_pkg::OPEN_W-1:0] close_dec;
    logic                       start;

    assign open_dec  = (r_open_cnt != '0) ? (r_open_cnt - 1'b1) : r_open_cnt;
    assign close_dec = (r_close_cnt != '0) ? (r_close_cnt - 1'b1) : r_close_cnt;
    assign start     = (i_temp_whole >= r_low) && (i_temp_whole < r_high)
                       && (open_dec == '0);

    always_comb begin
        n_peak      = r_peak;
        n_ival      = r_ival;
        n_open_cnt  = r_open_cnt;
        n_close_cnt = r_close_cnt;
        n_valve     = r_valve;
        if (i_advance) begin
            case (i_op)
                ait_pkg::OP_TICK: begin
                    if (i_temp_whole > r_peak) begin
                        n_peak = i_temp_whole;
                    end
                    n_open_cnt  = open_dec;
                    n_close_cnt = close_dec;
                    if (start) begin
                        n_valve     = 1'b1;
                        n_close_cnt = r_open_secs;
                        n_open_cnt  = r_ival;
                    end
                    // close once the open time has run out, even in the opening tick
                    if (n_close_cnt == '0) begin
                        n_valve = 1'b0;
                    end
                end
                ait_pkg::OP_DAILY: begin
                    n_ival = ait_pkg::INTERVAL_ROM[r_peak];
                    n_peak = ait_pkg::PEAK_RST;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low       <= ait_pkg::LOW_LIMIT_RST;
            r_high      <= ait_pkg::HIGH_LIMIT_RST;
            r_open_secs <= ait_pkg::OPEN_SECS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ait_pkg::CFG_LOW_LIMIT:  r_low       <= i_cfg_data[ait_pkg::TEMP_W-1:0];
                ait_pkg::CFG_HIGH_LIMIT: r_high      <= i_cfg_data[ait_pkg::TEMP_W-1:0];
                ait_pkg::CFG_OPEN_SECS:  r_open_secs <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= ait_pkg::PEAK_RST;
            r_ival      <= ait_pkg::IVAL_RST;
            r_open_cnt  <= ait_pkg::COUNTDOWN_RST;
            r_close_cnt <= '0;
            r_valve     <= 1'b0;
        end else begin
            r_peak      <= n_peak;
            r_ival      <= n_ival;
            r_open_cnt  <= n_open_cnt;
            r_close_cnt <= n_close_cnt;
            r_valve     <= n_valve;
        end
    end

    assign o_next.valve_open        = n_valve;
    assign o_next.max_temperature   = n_peak;
    assign o_next.watering_interval = n_ival;
    assign o_next.seconds_to_next   = n_open_cnt;

endmodule

FILE: rtl/adaptive_irrigation_timer_top.sv
// Top level of the adaptive irrigation valve timer.
// Depends on ait_pkg, ait_input_stage, ait_temp_filter and ait_valve_ctrl.
//
// Takes one request per clock (tick, temperature sample or daily reset in
// tuser) and returns one result per request with the valve state, whole-degree
// temperature, daily maximum, watering interval and open countdown after the
// update. The input register scales the sample, then a single pass updates
// all state and loads the result register, so a new request can be taken
// every cycle while the result side keeps up. The interval for a daily reset
// comes from a 256-entry constant ROM indexed by the day's maximum.
// Configuration writes take effect on the next clock.
module adaptive_irrigation_timer_top #(
    parameter int ADC_BITS        = ait_pkg::ADC_BITS_DEF,
    parameter int ADC_SCALE_SHIFT = ait_pkg::ADC_SCALE_SHIFT_DEF,
    parameter int S_DATA_W        = ((ADC_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // adc_sample
    input  logic [S_DATA_W-1:0]             i_s_axis_tdata,
    // opcode
    input  logic [ait_pkg::OP_W-1:0]        i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // valve_open, temperature_whole, max_temperature, watering_interval,
    // seconds_to_next
    output logic [ait_pkg::M_DATA_W-1:0]    o_m_axis_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [ait_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ait_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int RES_W = 1 + 2 * ait_pkg::TEMP_W + 2 * ait_pkg::IVAL_W;

    ait_pkg::t_item             item;
    ait_pkg::t_valve_status     valve_next;
    logic                       advance;
    logic [ait_pkg::TEMP_W-1:0] temp_whole;
    logic [ait_pkg::TEMP_W-1:0] temp_whole_next;
    logic                       r_out_valid;
    logic [RES_W-1:0]           r_out_data;

    // Move the held request into the result register when it is free or drained.
    assign advance = item.valid && (!r_out_valid || i_m_axis_tready);

    ait_input_stage #(
        .ADC_BITS        (ADC_BITS),
        .ADC_SCALE_SHIFT (ADC_SCALE_SHIFT),
        .S_DATA_W        (S_DATA_W)
    ) u_input_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_tdata   (i_s_axis_tdata),
        .i_tuser   (i_s_axis_tuser),
        .i_advance (advance),
        .o_item    (item)
    );

    ait_temp_filter u_temp_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_update     (advance && (item.op == ait_pkg::OP_SAMPLE)),
        .i_target     (item.target),
        .o_whole      (temp_whole),
        .o_whole_next (temp_whole_next)
    );

    ait_valve_ctrl u_valve_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_advance    (advance),
        .i_op         (item.op),
        .i_temp_whole (temp_whole),
        .o_next       (valve_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {valve_next.seconds_to_next, valve_next.watering_interval,
                           valve_next.max_temperature, temp_whole_next,
                           valve_next.valve_open};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = ait_pkg::M_DATA_W'(r_out_data);

endmodule

FILE: rtl/ait_checker.sv
// Port-level checks for the irrigation timer, bound to the top level.
// Depends on ait_pkg and adaptive_irrigation_timer_top_assert.svh.
`include "adaptive_irrigation_timer_top_assert.svh"

module ait_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_axis_tvalid,
    input logic                         o_s_axis_tready,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [ait_pkg::M_DATA_W-1:0] o_m_axis_tdata
);

    logic m_stall;
    logic s_accept;

    assign m_stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // hold a result that was not taken
    `AIT_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, m_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")

    // an empty result register never back-pressures requests
    `AIT_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "input stalled with empty result register")

    // the daily maximum never drops below its reset floor
    `AIT_ASSERT_IMPLY(a_max_floor, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[16:9] >= ait_pkg::PEAK_RST, "max temperature below floor")

    // a request taken into an idle pipe shows up after the input register and the result register
    `AIT_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, s_accept && !o_m_axis_tvalid && !$past(s_accept), ##1 o_m_axis_tvalid, "accepted request produced no result")

endmodule

bind adaptive_irrigation_timer_top ait_checker u_ait_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
